// ===== rtl/hsv_to_rgb_converter_unit_macros.svh =====
// Assertion macros used by the checker file of the converter.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH

// Check a property on every rising edge once reset is released.
`define HSVR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hsvr assertion failed");

// Check a property on every rising edge, reset cycles included.
`define HSVR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("hsvr assertion failed");

`endif

// ===== rtl/hsvr_pkg.sv =====
package hsvr_pkg;

    localparam int HUE_W    = 15;
    localparam int COMP_W   = 16;
    localparam int REM_W    = 12;
    localparam int FRAC_W   = 15;
    localparam int RAW_W    = 4;

    localparam int ONE          = 32768;
    localparam int SECTOR_UNITS = 3840;
    localparam int NUM_SECTORS  = 6;
    // Largest sector count a 15-bit hue can reach before the wrap.
    localparam int RAW_MAX      = (2 ** HUE_W - 1) / SECTOR_UNITS;

    // floor(rem * 128 / 15) == (rem * FRAC_RECIP) >> FRAC_SHIFT for rem < 3840
    localparam int FRAC_SHIFT   = 16;
    localparam int FRAC_RECIP   = 559241;

    // Number of register stages from input transfer to output register.
    localparam int PIPE_DEPTH   = 4;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } sector_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [COMP_W-1:0] sat;
        logic [COMP_W-1:0] val;
        logic [COMP_W-1:0] alpha;
    } hsva_t;

    typedef struct packed {
        sector_t           sector;
        logic [REM_W-1:0]  rem;
        logic [COMP_W-1:0] sat;
        logic [COMP_W-1:0] val;
        logic [COMP_W-1:0] alpha;
    } sect_t;

    typedef struct packed {
        sector_t           sector;
        logic [FRAC_W-1:0] frac;
        logic [COMP_W-1:0] sat;
        logic [COMP_W-1:0] val;
        logic [COMP_W-1:0] p;
        logic [COMP_W-1:0] alpha;
    } frac_t;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] alpha;
    } rgba_t;

    // Truncating Q1.15 product of two values no larger than 1.0.
    function automatic logic [COMP_W-1:0] q15_mul(input logic [COMP_W-1:0] a,
                                                  input logic [COMP_W-1:0] b);
        logic [2*COMP_W-1:0] prod;
        prod = {{COMP_W{1'b0}}, a} * {{COMP_W{1'b0}}, b};
        return prod[COMP_W+FRAC_W-1:FRAC_W];
    endfunction

endpackage

// ===== rtl/hsv_to_rgb_converter_unit.sv =====
// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   s_hue, s_saturation, s_value, s_alpha_in
// m_       out        m_valid / m_ready   m_red, m_green, m_blue, m_alpha_out
//
// One transfer in and one transfer out per cycle when nothing stalls.
// The four register stages are sector decode, reciprocal multiply for the
// fraction, scaled saturation, final product and channel select. Synchronous
// active-low reset clears the stage valid bits only. A stall on m_ready holds
// each occupied stage with no empty stage after it; other items still move
// into empty stages, so s_ready stays high until all four stages hold an item.
module hsv_to_rgb_converter_unit
    import hsvr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [HUE_W-1:0]  s_hue,
    input  logic [COMP_W-1:0] s_saturation,
    input  logic [COMP_W-1:0] s_value,
    input  logic [COMP_W-1:0] s_alpha_in,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [COMP_W-1:0] m_red,
    output logic [COMP_W-1:0] m_green,
    output logic [COMP_W-1:0] m_blue,
    output logic [COMP_W-1:0] m_alpha_out
);

    hsva_t in_data;
    sect_t sect_data;
    frac_t frac_data;
    rgba_t rgba_data;
    logic  sect_valid;
    logic  sect_ready;
    logic  frac_valid;
    logic  frac_ready;

    // gather the input fields into one item
    assign in_data.hue   = s_hue;
    assign in_data.sat   = s_saturation;
    assign in_data.val   = s_value;
    assign in_data.alpha = s_alpha_in;

    // stage 1: clamp saturation and value, split hue into sector and remainder
    hsvr_sector u_sector (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (in_data),
        .out_valid (sect_valid),
        .out_ready (sect_ready),
        .out_data  (sect_data)
    );

    // stage 2: fraction within the sector and the p term
    hsvr_frac u_frac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sect_valid),
        .in_ready  (sect_ready),
        .in_data   (sect_data),
        .out_valid (frac_valid),
        .out_ready (frac_ready),
        .out_data  (frac_data)
    );

    // stages 3 and 4: scaled saturation, then q and t terms and place components by sector
    hsvr_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (frac_valid),
        .in_ready  (frac_ready),
        .in_data   (frac_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (rgba_data)
    );

    assign m_red       = rgba_data.red;
    assign m_green     = rgba_data.green;
    assign m_blue      = rgba_data.blue;
    assign m_alpha_out = rgba_data.alpha;

endmodule

// ===== rtl/hsvr_sector.sv =====
module hsvr_sector
    import hsvr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  hsva_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output sect_t out_data
);

    logic       valid_reg;
    sect_t      data_reg;
    sect_t      data_next;
    logic [RAW_W-1:0] raw;
    logic [HUE_W-1:0] base;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        // count the sector boundaries at or below the hue
        raw = '0;
        for (int k = 1; k <= RAW_MAX; k++) begin
            if (in_data.hue >= HUE_W'(k * SECTOR_UNITS)) begin
                raw = raw + RAW_W'(1);
            end
        end
        base = HUE_W'(raw * SECTOR_UNITS);

        data_next.rem    = REM_W'(in_data.hue - base);
        data_next.sector = (raw >= RAW_W'(NUM_SECTORS))
                         ? sector_t'(3'(raw - RAW_W'(NUM_SECTORS)))
                         : sector_t'(raw[2:0]);
        data_next.sat    = (in_data.sat > COMP_W'(ONE)) ? COMP_W'(ONE) : in_data.sat;
        data_next.val    = (in_data.val > COMP_W'(ONE)) ? COMP_W'(ONE) : in_data.val;
        data_next.alpha  = in_data.alpha;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/hsvr_frac.sv =====
module hsvr_frac
    import hsvr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  sect_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output frac_t out_data
);

    logic        valid_reg;
    frac_t       data_reg;
    frac_t       data_next;
    logic [31:0] recip_prod;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        // divide by the sector width through its reciprocal
        recip_prod       = {20'd0, in_data.rem} * 32'(FRAC_RECIP);
        data_next.frac   = recip_prod[FRAC_SHIFT+FRAC_W-1:FRAC_SHIFT];
        data_next.p      = q15_mul(in_data.val, COMP_W'(ONE) - in_data.sat);
        data_next.sector = in_data.sector;
        data_next.sat    = in_data.sat;
        data_next.val    = in_data.val;
        data_next.alpha  = in_data.alpha;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/hsvr_blend.sv =====
module hsvr_blend
    import hsvr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  frac_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output rgba_t out_data
);

    // scaled-saturation stage
    logic              mid_valid_reg;
    logic              mid_ready;
    sector_t           sector_reg;
    logic [COMP_W-1:0] sf_reg;
    logic [COMP_W-1:0] sfc_reg;
    logic [COMP_W-1:0] val_reg;
    logic [COMP_W-1:0] p_reg;
    logic [COMP_W-1:0] alpha_reg;

    // output stage
    logic              out_valid_reg;
    rgba_t             rgba_reg;
    rgba_t             rgba_next;
    logic [COMP_W-1:0] q;
    logic [COMP_W-1:0] t;

    assign mid_ready = !out_valid_reg || out_ready;
    assign in_ready  = !mid_valid_reg || mid_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = rgba_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (in_ready) begin
            mid_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sector_reg <= in_data.sector;
            sf_reg     <= q15_mul(in_data.sat, {1'b0, in_data.frac});
            sfc_reg    <= q15_mul(COMP_W'(ONE) - {1'b0, in_data.frac}, in_data.sat);
            val_reg    <= in_data.val;
            p_reg      <= in_data.p;
            alpha_reg  <= in_data.alpha;
        end
    end

    always_comb begin
        q = q15_mul(val_reg, COMP_W'(ONE) - sf_reg);
        t = q15_mul(val_reg, COMP_W'(ONE) - sfc_reg);
        rgba_next.alpha = alpha_reg;
        unique case (sector_reg)
            SEC_RY: begin
                rgba_next.red = val_reg; rgba_next.green = t;       rgba_next.blue = p_reg;
            end
            SEC_YG: begin
                rgba_next.red = q;       rgba_next.green = val_reg; rgba_next.blue = p_reg;
            end
            SEC_GC: begin
                rgba_next.red = p_reg;   rgba_next.green = val_reg; rgba_next.blue = t;
            end
            SEC_CB: begin
                rgba_next.red = p_reg;   rgba_next.green = q;       rgba_next.blue = val_reg;
            end
            SEC_BM: begin
                rgba_next.red = t;       rgba_next.green = p_reg;   rgba_next.blue = val_reg;
            end
            default: begin
                rgba_next.red = val_reg; rgba_next.green = p_reg;   rgba_next.blue = q;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (mid_ready) begin
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_valid_reg && mid_ready) begin
            rgba_reg <= rgba_next;
        end
    end

endmodule

// ===== rtl/hsvr_checker.sv =====
`include "hsv_to_rgb_converter_unit_macros.svh"

module hsvr_checker
    import hsvr_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [COMP_W-1:0] m_red,
    input logic [COMP_W-1:0] m_green,
    input logic [COMP_W-1:0] m_blue,
    input logic [COMP_W-1:0] m_alpha_out
);

    // items taken in but not yet handed out
    logic [2:0] occ_reg;
    logic [2:0] occ_next;

    always_comb begin
        occ_next = occ_reg;
        if (s_valid && s_ready) begin
            occ_next = occ_next + 3'd1;
        end
        if (m_valid && m_ready) begin
            occ_next = occ_next - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    property p_out_hold;
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
            && $stable(m_blue) && $stable(m_alpha_out);
    endproperty

    property p_color_range;
        m_valid |-> m_red <= COMP_W'(ONE) && m_green <= COMP_W'(ONE)
            && m_blue <= COMP_W'(ONE);
    endproperty

    property p_occupancy;
        occ_reg <= 3'(PIPE_DEPTH) && (!m_valid || occ_reg != 3'd0);
    endproperty

    `HSVR_ASSERT(a_out_hold, aclk, aresetn, p_out_hold)
    `HSVR_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid)
    `HSVR_ASSERT(a_color_range, aclk, aresetn, p_color_range)
    `HSVR_ASSERT(a_occupancy, aclk, aresetn, p_occupancy)

endmodule

bind hsv_to_rgb_converter_unit hsvr_checker u_checker (.*);

// ===== tb/hsv_to_rgb_converter_unit_test.sv =====
`timescale 1ns / 1ps

module hsv_to_rgb_converter_unit_test;
    import hsvr_pkg::*;

    // Generous bound: every item could see a long sender gap plus a long sink
    // stall plus the pipeline, and the run is still far below this.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BLOCKS = 9;
    localparam int BLOCK_ITEMS   = 50;
    localparam int PRINT_CAP     = 30;

    // Expected pixel store plus fixed-point HSV predictor.
    class color_scoreboard;
        rgba_t       pending_rgba[$];
        int unsigned errors;
        int unsigned accepted;
        int unsigned checked;
        int unsigned sector_hits[NUM_SECTORS];

        task report_mismatch(string msg);
            if (errors < PRINT_CAP)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function int unsigned pending();
            return pending_rgba.size();
        endfunction

        // Clamp a Q1.15 component to 1.0.
        function int unsigned clamp_one(logic [COMP_W-1:0] x);
            return (x > ONE) ? ONE : x;
        endfunction

        function rgba_t convert(hsva_t px);
            int unsigned       s, v, rem, frac, p, q, t, sf, fs;
            logic [COMP_W-1:0] vc, pc, qc, tc;
            sector_t           sec;
            rgba_t             res;
            s    = clamp_one(px.sat);
            v    = clamp_one(px.val);
            // Hue past 360 degrees wraps back around the circle.
            sec  = sector_t'((px.hue / SECTOR_UNITS) % NUM_SECTORS);
            rem  = px.hue % SECTOR_UNITS;
            frac = (rem << FRAC_W) / SECTOR_UNITS;
            sf   = (s * frac) >> FRAC_W;
            fs   = ((ONE - frac) * s) >> FRAC_W;
            p    = (v * (ONE - s)) >> FRAC_W;
            q    = (v * (ONE - sf)) >> FRAC_W;
            t    = (v * (ONE - fs)) >> FRAC_W;
            vc   = COMP_W'(v);
            pc   = COMP_W'(p);
            qc   = COMP_W'(q);
            tc   = COMP_W'(t);
            case (sec)
                SEC_RY: begin res.red = vc; res.green = tc; res.blue = pc; end
                SEC_YG: begin res.red = qc; res.green = vc; res.blue = pc; end
                SEC_GC: begin res.red = pc; res.green = vc; res.blue = tc; end
                SEC_CB: begin res.red = pc; res.green = qc; res.blue = vc; end
                SEC_BM: begin res.red = tc; res.green = pc; res.blue = vc; end
                default: begin res.red = vc; res.green = pc; res.blue = qc; end
            endcase
            res.alpha = px.alpha;
            sector_hits[sec]++;
            return res;
        endfunction

        function void note_pixel(hsva_t px);
            rgba_t want;
            want = convert(px);
            pending_rgba = {pending_rgba, want};
            accepted++;
        endfunction

        task check_pixel(rgba_t got);
            rgba_t want;
            if (pending_rgba.size() == 0) begin
                report_mismatch($sformatf("result %h with no pixel outstanding", got));
            end else begin
                want = pending_rgba.pop_front();
                checked++;
                if (got.red !== want.red)
                    report_mismatch($sformatf("red %h, want %h", got.red, want.red));
                if (got.green !== want.green)
                    report_mismatch($sformatf("green %h, want %h", got.green, want.green));
                if (got.blue !== want.blue)
                    report_mismatch($sformatf("blue %h, want %h", got.blue, want.blue));
                if (got.alpha !== want.alpha)
                    report_mismatch($sformatf("alpha %h, want %h", got.alpha, want.alpha));
            end
        endtask
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [HUE_W-1:0]  s_hue = '0;
    logic [COMP_W-1:0] s_saturation = '0;
    logic [COMP_W-1:0] s_value = '0;
    logic [COMP_W-1:0] s_alpha_in = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [COMP_W-1:0] m_red;
    logic [COMP_W-1:0] m_green;
    logic [COMP_W-1:0] m_blue;
    logic [COMP_W-1:0] m_alpha_out;

    color_scoreboard sb;
    int unsigned     cycle_count = 0;
    int unsigned     stall_left = 0;
    // Idle enables; cleared to get stretches at full rate on that side.
    bit              sender_busy = 1'b0;
    bit              sink_busy = 1'b0;

    hsv_to_rgb_converter_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_hue       (s_hue),
        .s_saturation(s_saturation),
        .s_value     (s_value),
        .s_alpha_in  (s_alpha_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue),
        .m_alpha_out (m_alpha_out)
    );

    always #5 aclk = ~aclk;

    // Gap length: mostly none, often short, now and then long.
    function automatic int unsigned pick_gap(bit busy);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!busy || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Observe both channels at the edge; every value read here is the one
    // settled before the edge, so ordering inside the time step is moot.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_pixel('{hue: s_hue, sat: s_saturation, val: s_value,
                            alpha: s_alpha_in});
        if (aresetn && m_valid && m_ready)
            sb.check_pixel('{red: m_red, green: m_green, blue: m_blue,
                             alpha: m_alpha_out});
    end

    // Sink side: drop ready for random stretches, hold it high otherwise.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            int unsigned gap;
            gap = pick_gap(sink_busy);
            if (gap > 0) begin
                m_ready <= 1'b0;
                stall_left <= gap - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("FAIL");
            $finish;
        end
    end

    // Present one pixel and hold it until the transfer. Valid stays high
    // across back-to-back pixels, so this task only lowers it when a gap is taken.
    task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [COMP_W-1:0] sat,
                              input logic [COMP_W-1:0] val, input logic [COMP_W-1:0] alpha);
        int unsigned gap;
        gap = pick_gap(sender_busy);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_hue        <= hue;
        s_saturation <= sat;
        s_value      <= val;
        s_alpha_in   <= alpha;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold off the sender until every outstanding pixel has come back.
    // Step one edge first so the last transfer is already on the books.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() > 0) @(posedge aclk);
    endtask

    // Random pixel, weighted toward legal colors but covering every corner.
    task automatic send_random_pixel();
        logic [HUE_W-1:0]  hue;
        logic [COMP_W-1:0] sat, val, alpha;
        int unsigned       kind;
        kind  = $urandom_range(0, 9);
        hue   = HUE_W'($urandom_range(0, 23040));
        sat   = COMP_W'($urandom_range(0, ONE));
        val   = COMP_W'($urandom_range(0, ONE));
        alpha = COMP_W'($urandom_range(0, ONE));
        if (kind == 6) begin
            // Full field width: reaches every bit of every input port.
            hue   = HUE_W'($urandom);
            sat   = COMP_W'($urandom);
            val   = COMP_W'($urandom);
            alpha = COMP_W'($urandom);
        end else if (kind == 7) begin
            // Sector boundaries with near-zero or near-full components.
            hue = HUE_W'($urandom_range(0, 8) * SECTOR_UNITS + $urandom_range(0, 2) - 1);
            sat = ($urandom_range(0, 1) == 1) ? COMP_W'(ONE - $urandom_range(0, 1))
                                              : COMP_W'($urandom_range(0, 1));
            val = ($urandom_range(0, 1) == 1) ? COMP_W'(ONE - $urandom_range(0, 1))
                                              : COMP_W'($urandom_range(0, 1));
        end else if (kind == 8) begin
            // Past 360 degrees: wraps into the first sectors again.
            hue = HUE_W'($urandom_range(23041, 32767));
        end else if (kind == 9) begin
            // Saturation, value and alpha above 1.0.
            sat   = COMP_W'($urandom_range(ONE + 1, 65535));
            val   = COMP_W'($urandom_range(ONE + 1, 65535));
            alpha = COMP_W'($urandom_range(ONE + 1, 65535));
        end
        send_pixel(hue, sat, val, alpha);
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: black, white, every sector start, the ends of the first, second and
        // last sectors, the 360 degree wrap, the top of the hue field, and clamped inputs.
        send_pixel(0, 0, 0, 0);
        send_pixel(0, ONE, ONE, ONE);
        send_pixel(0, 0, ONE, 16384);
        send_pixel(0, ONE, 0, 65535);
        send_pixel(SECTOR_UNITS - 1, ONE, ONE, 1);
        send_pixel(SECTOR_UNITS, ONE, ONE, 2);
        send_pixel(2 * SECTOR_UNITS - 1, ONE, ONE, 3);
        send_pixel(2 * SECTOR_UNITS, 20000, 30000, 4);
        send_pixel(3 * SECTOR_UNITS, ONE, ONE, 5);
        send_pixel(3 * SECTOR_UNITS + 1920, 16384, ONE, 6);
        send_pixel(4 * SECTOR_UNITS, ONE, ONE, 7);
        send_pixel(4 * SECTOR_UNITS + 3000, ONE, 12345, 8);
        send_pixel(5 * SECTOR_UNITS, ONE, ONE, 9);
        send_pixel(6 * SECTOR_UNITS - 1, ONE, ONE, 10);
        send_pixel(23040, ONE, ONE, 11);
        send_pixel(7 * SECTOR_UNITS + 100, ONE, ONE, 12);
        send_pixel(8 * SECTOR_UNITS + 2000, 30000, ONE, 13);
        send_pixel(32767, 65535, 65535, 65535);
        send_pixel(1920, 65535, ONE, ONE);
        send_pixel(1920, ONE, 65535, ONE);
        send_pixel(5760, ONE + 1, ONE + 1, ONE + 1);
        send_pixel(1, 1, 1, 1);
        send_pixel(2 * SECTOR_UNITS + 1, 32767, 32767, 32767);
        drain_results();

        // Random blocks: some at full rate on both sides, others with gaps
        // and stalls; drain now and then so the pipe also empties mid-run.
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            sender_busy = (blk % 3 != 0) && ($urandom_range(0, 3) != 0);
            sink_busy   = (blk % 3 != 0) && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < BLOCK_ITEMS; i++)
                send_random_pixel();
            if (blk % 3 == 2)
                drain_results();
        end
        sender_busy = 1'b1;
        sink_busy   = 1'b1;

        drain_results();
        // Let anything stray fall out of the pipe before judging.
        repeat (PIPE_DEPTH + 8) @(posedge aclk);

        $display("run covered %0d pixels in, %0d colors checked, %0d mismatches",
                 sb.accepted, sb.checked, sb.errors);
        $display("sector hits: %0d %0d %0d %0d %0d %0d", sb.sector_hits[0],
                 sb.sector_hits[1], sb.sector_hits[2], sb.sector_hits[3],
                 sb.sector_hits[4], sb.sector_hits[5]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
